// ----- src/murmur2_hash_engine_core_defines.svh -----
// ----------------------------------------------------------------------------
// murmur2 hash engine assertion macros
// shared concurrent assertion helpers, clocked on aclk, off during reset
// ----------------------------------------------------------------------------
`ifndef MURMUR2_HASH_ENGINE_CORE_DEFINES_SVH
`define MURMUR2_HASH_ENGINE_CORE_DEFINES_SVH

// same-cycle implication
`define MH2_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mh2 check failed");

// next-cycle implication
`define MH2_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mh2 check failed");

`endif

// ----- src/mh2_pkg.sv -----
// ----------------------------------------------------------------------------
// mh2_pkg
// types, constants and helpers shared by the murmur2 hash engine
// ----------------------------------------------------------------------------
package mh2_pkg;

    localparam logic [31:0] MIX_M    = 32'h5bd1e995;
    localparam logic [31:0] SEED_MUL = 32'hdeadbeef;
    localparam int unsigned SHIFT_K  = 24;
    localparam int unsigned SHIFT_F1 = 13;
    localparam int unsigned SHIFT_F2 = 15;

    typedef enum logic [1:0] {
        CNT_ZERO,
        CNT_PART,
        CNT_FULL
    } cnt_class_t;

    typedef enum logic [2:0] {
        MUL_SEED,
        MUL_KMIX1,
        MUL_KMIX2,
        MUL_HMUL,
        MUL_TAIL,
        MUL_FIN
    } mul_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_KMIX1,
        ST_KMIX2,
        ST_HMUL,
        ST_TAIL,
        ST_FIN
    } state_t;

    typedef struct packed {
        mul_op_t op;
        logic    load_h;
        logic    load_k;
        logic    load_out;
    } ctrl_t;

    // counts above four act as a full word
    function automatic cnt_class_t count_class(input logic [2:0] cnt);
        cnt_class_t cls;
        case (cnt)
            3'd0:                      cls = CNT_ZERO;
            3'd1, 3'd2, 3'd3:          cls = CNT_PART;
            default:                   cls = CNT_FULL;
        endcase
        return cls;
    endfunction

    function automatic logic [31:0] tail_mask(input logic [2:0] cnt);
        logic [31:0] m;
        case (cnt)
            3'd1:    m = 32'h0000_00ff;
            3'd2:    m = 32'h0000_ffff;
            3'd3:    m = 32'h00ff_ffff;
            default: m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

endpackage

// ----- src/murmur2_hash_engine_core.sv -----
// ----------------------------------------------------------------------------
// murmur2_hash_engine_core
// 32-bit murmur2 hash over a key streamed as little-endian 32-bit words
// ----------------------------------------------------------------------------
// usage:
//   s_ channel: one beat per key word; s_byte_count gives valid bytes (4 on
//   all but the last word, 0 for an empty key), s_last marks the final word,
//   s_key_length is sampled on the first word of each key and seeds the hash.
//   m_ channel: one beat per key, m_hash_value after the last word.
// sequencing: one shared 32x32 multiplier is stepped by a sequencer, so
//   s_ready is low while a word is in work. A full word passes accept and
//   three multiplies, a partial word accept and one tail multiply; the first
//   word of a key adds the seed multiply, the last word adds the final
//   avalanche multiply. m_valid rises at the edge that ends the finalize
//   step, together with s_ready.
// stall: the result waits in an output register; the next key may start
//   meanwhile, and the block only holds in the finalize step if a new hash
//   is ready before the previous one was taken.
// reset: aresetn low returns the sequencer to idle, awaiting the first word
//   of a new key, and drops m_valid.
// ----------------------------------------------------------------------------
`include "murmur2_hash_engine_core_defines.svh"

module murmur2_hash_engine_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_byte_count,
    input  logic        s_last,
    input  logic [31:0] s_key_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_hash_value
);
    import mh2_pkg::*;

    ctrl_t       ctrl;
    logic        accept;
    logic        out_free;
    logic [31:0] mul_result;

    logic [31:0] word_reg, word_next;
    logic [31:0] len_reg, len_next;
    logic [2:0]  count_reg, count_next;
    logic [31:0] h_reg, h_next;
    logic [31:0] k_reg, k_next;
    logic [31:0] hash_reg, hash_next;
    logic        m_valid_reg, m_valid_next;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    mh2_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_byte_count (s_byte_count),
        .s_last       (s_last),
        .out_free     (out_free),
        .s_ready      (s_ready),
        .ctrl         (ctrl)
    );

    mh2_mul_unit u_mul (
        .op         (ctrl.op),
        .h          (h_reg),
        .k          (k_reg),
        .word       (word_reg),
        .len        (len_reg),
        .byte_count (count_reg),
        .result     (mul_result)
    );

    always_comb begin
        word_next    = accept ? s_data_word  : word_reg;
        len_next     = accept ? s_key_length : len_reg;
        count_next   = accept ? s_byte_count : count_reg;
        h_next       = ctrl.load_h   ? mul_result : h_reg;
        k_next       = ctrl.load_k   ? mul_result : k_reg;
        hash_next    = ctrl.load_out ? mul_result : hash_reg;
        m_valid_next = ctrl.load_out ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    // datapath, no reset needed
    always_ff @(posedge aclk) begin
        word_reg  <= word_next;
        len_reg   <= len_next;
        count_reg <= count_next;
        h_reg     <= h_next;
        k_reg     <= k_next;
        hash_reg  <= hash_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_hash_value = hash_reg;

    `MH2_ASSERT_NOW(a_out_no_overwrite, ctrl.load_out, !m_valid_reg || m_ready)
    `MH2_ASSERT_NOW(a_idle_no_load, s_ready, !(ctrl.load_h || ctrl.load_k || ctrl.load_out))
    `MH2_ASSERT_NEXT(a_last_busy, accept && s_last, !s_ready)

endmodule

// ----- src/mh2_mul_unit.sv -----
// ----------------------------------------------------------------------------
// mh2_mul_unit
// shared 32x32 multiplier with operand select and xor/shift post-ops
// ----------------------------------------------------------------------------
module mh2_mul_unit (
    input  mh2_pkg::mul_op_t op,
    input  logic [31:0]      h,
    input  logic [31:0]      k,
    input  logic [31:0]      word,
    input  logic [31:0]      len,
    input  logic [2:0]       byte_count,
    output logic [31:0]      result
);
    import mh2_pkg::*;

    logic [31:0] opa;
    logic [31:0] opb;
    logic [63:0] full_prod;
    logic [31:0] prod;

    always_comb begin
        opb = MIX_M;
        case (op)
            MUL_SEED: begin
                opa = len;
                opb = SEED_MUL;
            end
            MUL_KMIX1: opa = word;
            MUL_KMIX2: opa = k ^ (k >> SHIFT_K);
            MUL_HMUL:  opa = h;
            MUL_TAIL:  opa = h ^ (word & tail_mask(byte_count));
            MUL_FIN:   opa = h ^ (h >> SHIFT_F1);
            default:   opa = h;
        endcase
    end

    assign full_prod = {32'd0, opa} * {32'd0, opb};
    assign prod      = full_prod[31:0];

    always_comb begin
        case (op)
            MUL_SEED: result = prod ^ len;
            MUL_HMUL: result = prod ^ k;
            MUL_FIN:  result = prod ^ (prod >> SHIFT_F2);
            default:  result = prod;
        endcase
    end

endmodule

// ----- src/mh2_ctrl.sv -----
// ----------------------------------------------------------------------------
// mh2_ctrl
// sequencer stepping the shared multiplier through seed, mix, tail and finalize
// ----------------------------------------------------------------------------
`include "murmur2_hash_engine_core_defines.svh"

module mh2_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic [2:0]    s_byte_count,
    input  logic          s_last,
    input  logic          out_free,
    output logic          s_ready,
    output mh2_pkg::ctrl_t ctrl
);
    import mh2_pkg::*;

    state_t     state_reg, state_next;
    logic       inside_reg, inside_next;
    cnt_class_t cls_reg, cls_next;
    logic       last_reg, last_next;
    logic       accept;

    function automatic state_t dispatch(input cnt_class_t cls, input logic lst);
        state_t s;
        case (cls)
            CNT_FULL: s = ST_KMIX1;
            CNT_PART: s = ST_TAIL;
            default:  s = lst ? ST_FIN : ST_IDLE;
        endcase
        return s;
    endfunction

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        inside_next = inside_reg;
        cls_next    = cls_reg;
        last_next   = last_reg;
        if (accept) begin
            inside_next = !s_last;
            cls_next    = count_class(s_byte_count);
            last_next   = s_last;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = inside_reg ? dispatch(count_class(s_byte_count), s_last)
                                            : ST_SEED;
                end
            end
            ST_SEED:  state_next = dispatch(cls_reg, last_reg);
            ST_KMIX1: state_next = ST_KMIX2;
            ST_KMIX2: state_next = ST_HMUL;
            ST_HMUL,
            ST_TAIL:  state_next = last_reg ? ST_FIN : ST_IDLE;
            ST_FIN:   state_next = out_free ? ST_IDLE : ST_FIN;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '{op: MUL_SEED, load_h: 1'b0, load_k: 1'b0, load_out: 1'b0};
        case (state_reg)
            ST_SEED: begin
                ctrl.op     = MUL_SEED;
                ctrl.load_h = 1'b1;
            end
            ST_KMIX1: begin
                ctrl.op     = MUL_KMIX1;
                ctrl.load_k = 1'b1;
            end
            ST_KMIX2: begin
                ctrl.op     = MUL_KMIX2;
                ctrl.load_k = 1'b1;
            end
            ST_HMUL: begin
                ctrl.op     = MUL_HMUL;
                ctrl.load_h = 1'b1;
            end
            ST_TAIL: begin
                ctrl.op     = MUL_TAIL;
                ctrl.load_h = 1'b1;
            end
            ST_FIN: begin
                ctrl.op       = MUL_FIN;
                ctrl.load_out = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            inside_reg <= 1'b0;
            cls_reg    <= CNT_ZERO;
            last_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            inside_reg <= inside_next;
            cls_reg    <= cls_next;
            last_reg   <= last_next;
        end
    end

    `MH2_ASSERT_NEXT(a_kmix_order, state_reg == ST_KMIX1, state_reg == ST_KMIX2)
    `MH2_ASSERT_NEXT(a_seed_once, state_reg == ST_SEED, state_reg != ST_SEED)
    `MH2_ASSERT_NEXT(a_done_idle, ctrl.load_out, (state_reg == ST_IDLE) && !inside_reg)

endmodule
